@@ hdl/ghc_pkg.sv @@
// Ground hazard classifier package: field widths, codes, configuration and
// stage types shared by the interfaces and all modules. No dependencies.
package ghc_pkg;

    localparam int RANGE_W = 16;
    localparam int DEV_W   = 27;
    localparam int CFG_W   = 26;
    localparam int IDX_W   = 3;

    localparam logic [1:0] LEVEL_SAFE    = 2'd0;
    localparam logic [1:0] LEVEL_CAUTION = 2'd1;
    localparam logic [1:0] LEVEL_DANGER  = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HOLE = 2'd1;
    localparam logic [1:0] KIND_STEP = 2'd2;

    localparam logic [IDX_W-1:0] CFG_BASELINE    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SLOPE       = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ADVANCE     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FOOTPRINT   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SAFE_GAP    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_STEP_ENTER  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_HOLE_ENTER  = 3'd6;
    localparam logic [IDX_W-1:0] CFG_STEP_DANGER = 3'd7;

    localparam logic [16:0] SLOPE_ONE          = 17'd65536;
    localparam logic [19:0] SAFE_GAP_RST       = 20'd42000;
    localparam logic [19:0] STEP_ENTER_RST     = 20'd20000;
    localparam logic [19:0] HOLE_ENTER_RST     = 20'd40000;
    localparam logic [19:0] STEP_DANGER_RST    = 20'd40000;
    localparam logic signed [27:0] EXIT_UM     = 28'sd10000;
    localparam logic [23:0] WIDTH_MAX          = 24'hFFFFFF;

    typedef struct packed {
        logic [25:0] baseline_um;
        logic [16:0] slope_q16;
        logic [15:0] advance_um;
        logic [19:0] footprint_um;
        logic [19:0] safe_gap_um;
        logic [19:0] step_enter_um;
        logic [19:0] hole_enter_um;
        logic [19:0] step_danger_um;
    } ghc_cfg_t;

    typedef struct packed {
        logic                    echo;
        logic signed [DEV_W-1:0] dev;
    } ghc_dev_t;

endpackage

@@ hdl/ghc_in_if.sv @@
// Sample channel: valid/ready handshake carrying one range sample.
// Depends on ghc_pkg.
interface ghc_in_if import ghc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;

    modport source (output valid, output range_mm, input ready);
    modport sink (input valid, input range_mm, output ready);
endinterface

@@ hdl/ghc_out_if.sv @@
// Result channel: valid/ready handshake carrying one hazard grade.
// Depends on ghc_pkg.
interface ghc_out_if import ghc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              risk_level;
    logic [1:0]              hazard_kind;
    logic signed [DEV_W-1:0] deviation_um;

    modport source (output valid, output risk_level, output hazard_kind,
                    output deviation_um, input ready);
    modport sink (input valid, input risk_level, input hazard_kind,
                  input deviation_um, output ready);
endinterface

@@ hdl/ghc_front.sv @@
// Front end: sample history, 3-tap median, baseline subtract and slope scaling
// in a three-stage pipeline. Depends on ghc_pkg and ghc_in_if.
module ghc_front import ghc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ghc_cfg_t   cfg,
    ghc_in_if.sink     sample,
    output logic       item_valid,
    input  logic       item_ready,
    output ghc_dev_t   item
);

    logic [RANGE_W-1:0] hist0_reg, hist1_reg;
    logic [1:0]         fill_reg;

    logic               s1_valid_reg, s1_echo_reg;
    logic [RANGE_W-1:0] s1_v_reg;
    logic               s2_valid_reg, s2_echo_reg;
    logic signed [26:0] s2_diff_reg;
    logic               s3_valid_reg;
    ghc_dev_t           s3_reg;

    logic               s1_ready, s2_ready, s3_ready;
    logic               accept;
    logic               echo;
    logic [RANGE_W-1:0] lo_ab, hi_ab, med, v_next;
    logic [25:0]        range_um;
    logic signed [26:0] diff;
    logic [16:0]        slope_eff;
    logic signed [44:0] prod, rounded;

    assign s3_ready     = !s3_valid_reg || item_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample.ready = s1_ready;
    assign accept       = sample.valid && s1_ready;
    assign echo         = (sample.range_mm != '0);

    assign lo_ab  = (sample.range_mm < hist0_reg) ? sample.range_mm : hist0_reg;
    assign hi_ab  = (sample.range_mm < hist0_reg) ? hist0_reg : sample.range_mm;
    assign med    = (hi_ab < hist1_reg) ? hi_ab : ((lo_ab > hist1_reg) ? lo_ab : hist1_reg);
    assign v_next = (fill_reg >= 2'd2) ? med : sample.range_mm;

    assign range_um = {10'd0, s1_v_reg} * 26'd1000;
    assign diff     = $signed({1'b0, range_um}) - $signed({1'b0, cfg.baseline_um});

    assign slope_eff = (cfg.slope_q16 > SLOPE_ONE) ? SLOPE_ONE : cfg.slope_q16;
    assign prod      = s2_diff_reg * $signed({1'b0, slope_eff});
    assign rounded   = prod + 45'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg    <= '0;
            hist1_reg    <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (echo)
                begin
                    hist0_reg <= sample.range_mm;
                    hist1_reg <= hist0_reg;
                    if (fill_reg != 2'd3)
                    begin
                        fill_reg <= fill_reg + 2'd1;
                    end
                end
                else
                begin
                    fill_reg <= '0;
                end
            end
            if (s1_ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_v_reg    <= v_next;
            s1_echo_reg <= echo;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_diff_reg <= diff;
            s2_echo_reg <= s1_echo_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg.dev  <= rounded[42:16];
            s3_reg.echo <= s2_echo_reg;
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_reg;

    a_no_echo_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !echo |=> fill_reg == 2'd0)
        else $error("median fill not restarted after no-echo sample");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !item_ready |=> s3_valid_reg && $stable(s3_reg))
        else $error("stage 3 item lost while stalled");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_diff_reg))
        else $error("stage 2 item lost while stalled");

endmodule

@@ hdl/ghc_classify.sv @@
// Hazard state machine (idle/hole/step) and result register.
// Depends on ghc_pkg and ghc_out_if.
module ghc_classify import ghc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ghc_cfg_t   cfg,
    input  logic       item_valid,
    output logic       item_ready,
    input  ghc_dev_t   item,
    ghc_out_if.source  result
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_HOLE = 3'b010,
        MODE_STEP = 3'b100
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [23:0] width_reg, width_next;
    logic [26:0] peak_reg, peak_next;
    logic        out_valid_reg;
    logic [1:0]  risk_reg, risk_next;
    logic [1:0]  kind_reg, kind_next;
    logic signed [DEV_W-1:0] dev_reg;

    logic               take;
    logic signed [27:0] dev_x, rise, peak_x, peak_max;
    logic [24:0]        w_sum;
    logic [23:0]        w;
    logic               w_danger, w_caution;

    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;

    assign dev_x     = {item.dev[DEV_W-1], item.dev};
    assign rise      = -dev_x;
    assign peak_x    = $signed({1'b0, peak_reg});
    assign peak_max  = (rise > peak_x) ? rise : peak_x;
    assign w_sum     = {1'b0, width_reg} + {9'd0, cfg.advance_um};
    assign w         = w_sum[24] ? WIDTH_MAX : w_sum[23:0];
    assign w_danger  = (w >= {4'd0, cfg.safe_gap_um});
    assign w_caution = ({w, 1'b0} >= {5'd0, cfg.safe_gap_um});

    always_comb
    begin
        mode_next  = mode_reg;
        width_next = width_reg;
        peak_next  = peak_reg;
        risk_next  = LEVEL_SAFE;
        kind_next  = KIND_NONE;
        if (item.echo)
        begin
            case (mode_reg)
                MODE_HOLE:
                begin
                    width_next = w;
                    if (dev_x < EXIT_UM)
                    begin
                        if (w_danger)
                        begin
                            risk_next = LEVEL_DANGER;
                            kind_next = KIND_HOLE;
                        end
                        else if (w_caution)
                        begin
                            risk_next = LEVEL_CAUTION;
                            kind_next = KIND_HOLE;
                        end
                        mode_next  = MODE_IDLE;
                        width_next = '0;
                    end
                    else if (w_danger)
                    begin
                        risk_next  = LEVEL_DANGER;
                        kind_next  = KIND_HOLE;
                        mode_next  = MODE_IDLE;
                        width_next = '0;
                    end
                    else if (w_caution)
                    begin
                        risk_next = LEVEL_CAUTION;
                        kind_next = KIND_HOLE;
                    end
                end
                MODE_STEP:
                begin
                    peak_next = peak_max[26:0];
                    if (peak_max >= $signed({8'd0, cfg.step_danger_um}))
                    begin
                        risk_next = LEVEL_DANGER;
                        kind_next = KIND_STEP;
                        mode_next = MODE_IDLE;
                        peak_next = '0;
                    end
                    else if (rise < EXIT_UM)
                    begin
                        mode_next = MODE_IDLE;
                        peak_next = '0;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (dev_x > $signed({8'd0, cfg.hole_enter_um}))
                    begin
                        mode_next  = MODE_HOLE;
                        width_next = {4'd0, cfg.footprint_um};
                    end
                    else if (rise > $signed({8'd0, cfg.step_enter_um}))
                    begin
                        mode_next = MODE_STEP;
                        peak_next = rise[26:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            width_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                width_reg <= width_next;
                peak_reg  <= peak_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            risk_reg <= risk_next;
            kind_reg <= kind_next;
            dev_reg  <= item.echo ? item.dev : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.risk_level   = risk_reg;
    assign result.hazard_kind  = kind_reg;
    assign result.deviation_um = dev_reg;

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> width_reg == '0 && peak_reg == '0)
        else $error("hole width or step peak left over in idle");

    a_risk_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (risk_reg == LEVEL_SAFE) == (kind_reg == KIND_NONE))
        else $error("risk and hazard kind disagree");

    a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item.echo |=> out_valid_reg && risk_reg == LEVEL_SAFE
            && kind_reg == KIND_NONE && dev_reg == '0 && $stable(mode_reg))
        else $error("no-echo sample changed state or result");

endmodule

@@ hdl/ground_hazard_classifier_core.sv @@
// Ground hazard classifier top level: configuration registers, front-end
// pipeline and hazard state machine. Depends on ghc_pkg, ghc_in_if, ghc_out_if,
// ghc_front and ghc_classify.
//
// One range sample is accepted per clock unless back-pressure stalls the
// pipeline, and one result transfer leaves per sample when the result side
// is ready. The front end (median, baseline subtract, slope multiply) is three
// register stages; the hole/step state machine updates in the fourth stage,
// which closes its feedback loop and so sets the one-sample-per-cycle rate.
// Back-pressure stalls each stage only when the stage after it is full.
// Configuration writes take effect on the next clock and belong in idle time.
module ground_hazard_classifier_core import ghc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ghc_in_if.sink           sample,
    ghc_out_if.source        result
);

    ghc_cfg_t cfg_reg;
    ghc_dev_t item;
    logic     item_valid;
    logic     item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline_um    <= '0;
            cfg_reg.slope_q16      <= SLOPE_ONE;
            cfg_reg.advance_um     <= '0;
            cfg_reg.footprint_um   <= '0;
            cfg_reg.safe_gap_um    <= SAFE_GAP_RST;
            cfg_reg.step_enter_um  <= STEP_ENTER_RST;
            cfg_reg.hole_enter_um  <= HOLE_ENTER_RST;
            cfg_reg.step_danger_um <= STEP_DANGER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASELINE:    cfg_reg.baseline_um    <= cfg_data;
                CFG_SLOPE:       cfg_reg.slope_q16      <= cfg_data[16:0];
                CFG_ADVANCE:     cfg_reg.advance_um     <= cfg_data[15:0];
                CFG_FOOTPRINT:   cfg_reg.footprint_um   <= cfg_data[19:0];
                CFG_SAFE_GAP:    cfg_reg.safe_gap_um    <= cfg_data[19:0];
                CFG_STEP_ENTER:  cfg_reg.step_enter_um  <= cfg_data[19:0];
                CFG_HOLE_ENTER:  cfg_reg.hole_enter_um  <= cfg_data[19:0];
                CFG_STEP_DANGER: cfg_reg.step_danger_um <= cfg_data[19:0];
                default:         cfg_reg.baseline_um    <= cfg_reg.baseline_um;
            endcase
        end
    end

    ghc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample     (sample),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    ghc_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .result     (result)
    );

endmodule

@@ tb/ground_hazard_classifier_core_tb.sv @@
// Self-checking testbench for ground_hazard_classifier_core: drives range samples
// through random gaps and stalls and checks every grade against a predictor.
// Depends on ghc_pkg, ghc_in_if, ghc_out_if and the core.
module ground_hazard_classifier_core_tb;
    import ghc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          EXIT_LEVEL_UM = 10000;
    localparam int unsigned WIDTH_CAP     = 24'hFFFFFF;
    localparam logic [16:0] SLOPE_CAP     = 17'd65536;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          NUM_PHASES    = 6;

    typedef struct packed {
        logic [25:0] baseline_um;
        logic [16:0] slope_q16;
        logic [15:0] advance_um;
        logic [19:0] footprint_um;
        logic [19:0] safe_gap_um;
        logic [19:0] step_enter_um;
        logic [19:0] hole_enter_um;
        logic [19:0] step_danger_um;
    } hazard_cfg_t;

    typedef enum logic [1:0] {TRACK_IDLE, TRACK_HOLE, TRACK_STEP} track_mode_t;

    typedef struct packed {
        logic [1:0]              risk;
        logic [1:0]              kind;
        logic signed [DEV_W-1:0] dev;
    } grade_t;

    localparam hazard_cfg_t RESET_CFG = '{26'd0, 17'd65536, 16'd0, 20'd0,
                                          20'd42000, 20'd20000, 20'd40000, 20'd40000};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ghc_in_if  sample_if ();
    ghc_out_if result_if ();

    ground_hazard_classifier_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_if),
        .result    (result_if)
    );

    // predictor state
    hazard_cfg_t  model_cfg = RESET_CFG;
    track_mode_t  trk_mode  = TRACK_IDLE;
    logic [23:0]  trk_width = '0;
    int           trk_peak  = 0;
    logic [15:0]  hist [3]  = '{16'd0, 16'd0, 16'd0};
    int           hist_fill = 0;

    logic [15:0]  sample_q [$];
    grade_t       grade_q [$];
    grade_t       want;

    int src_idle_pct = 10;
    int snk_idle_pct = 47;
    int errors       = 0;
    int samples_sent = 0;
    int checked      = 0;
    int blanks       = 0;
    int hole_cautions = 0;
    int hole_dangers = 0;
    int step_dangers = 0;
    int quiet        = 0;

    hazard_cfg_t setting [NUM_PHASES];
    int          phase_items [NUM_PHASES] = '{220, 190, 60, 220, 220, 220};
    int unsigned warmup_mm [5]  = '{0, 65535, 1, 65535, 65535};
    int unsigned terrain_mm [20] = '{300, 300, 300, 370, 370, 370, 370, 370, 370, 300,
                                     300, 250, 250, 250, 250, 230, 230, 0, 300, 0};

    function automatic void grade_sample(input logic [15:0] mm);
        grade_t      g;
        logic [15:0] a, b, c, t, mid;
        logic [16:0] slope;
        longint      prod;
        int          dev, rise;
        int unsigned w;
        g = '{LEVEL_SAFE, KIND_NONE, '0};
        if (mm == 16'd0)
        begin
            hist_fill = 0;
            grade_q.push_back(g);
            return;
        end
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = mm;
        if (hist_fill < 3)
            hist_fill++;
        mid = mm;
        if (hist_fill == 3)
        begin
            a = hist[0];
            b = hist[1];
            c = hist[2];
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            mid = (c < a) ? a : ((c > b) ? b : c);
        end
        slope = (model_cfg.slope_q16 > SLOPE_CAP) ? SLOPE_CAP : model_cfg.slope_q16;
        prod  = (longint'(mid) * 1000 - longint'(model_cfg.baseline_um)) * longint'(slope)
                + 32768;
        dev   = int'(prod >>> 16);
        g.dev = dev[DEV_W-1:0];
        case (trk_mode)
            TRACK_HOLE:
            begin
                w = trk_width + model_cfg.advance_um;
                if (w > WIDTH_CAP)
                    w = WIDTH_CAP;
                trk_width = w[23:0];
                if (dev < EXIT_LEVEL_UM)
                begin
                    if (w >= model_cfg.safe_gap_um)
                        {g.risk, g.kind} = {LEVEL_DANGER, KIND_HOLE};
                    else if ((w << 1) >= model_cfg.safe_gap_um)
                        {g.risk, g.kind} = {LEVEL_CAUTION, KIND_HOLE};
                    trk_mode  = TRACK_IDLE;
                    trk_width = '0;
                end
                else if (w >= model_cfg.safe_gap_um)
                begin
                    {g.risk, g.kind} = {LEVEL_DANGER, KIND_HOLE};
                    trk_mode  = TRACK_IDLE;
                    trk_width = '0;
                end
                else if ((w << 1) >= model_cfg.safe_gap_um)
                begin
                    {g.risk, g.kind} = {LEVEL_CAUTION, KIND_HOLE};
                end
            end
            TRACK_STEP:
            begin
                rise = -dev;
                if (rise > trk_peak)
                    trk_peak = rise;
                if (trk_peak >= int'(model_cfg.step_danger_um))
                begin
                    {g.risk, g.kind} = {LEVEL_DANGER, KIND_STEP};
                    trk_mode = TRACK_IDLE;
                    trk_peak = 0;
                end
                else if (rise < EXIT_LEVEL_UM)
                begin
                    trk_mode = TRACK_IDLE;
                    trk_peak = 0;
                end
            end
            default:
            begin
                trk_mode = TRACK_IDLE;
                if (dev > int'(model_cfg.hole_enter_um))
                begin
                    trk_mode  = TRACK_HOLE;
                    trk_width = {4'd0, model_cfg.footprint_um};
                end
                else if (-dev > int'(model_cfg.step_enter_um))
                begin
                    trk_mode = TRACK_STEP;
                    trk_peak = -dev;
                end
            end
        endcase
        grade_q.push_back(g);
    endfunction

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic write_settings(input hazard_cfg_t c);
        put_reg(CFG_BASELINE, c.baseline_um);
        put_reg(CFG_SLOPE, CFG_W'(c.slope_q16));
        put_reg(CFG_ADVANCE, CFG_W'(c.advance_um));
        put_reg(CFG_FOOTPRINT, CFG_W'(c.footprint_um));
        put_reg(CFG_SAFE_GAP, CFG_W'(c.safe_gap_um));
        put_reg(CFG_STEP_ENTER, CFG_W'(c.step_enter_um));
        put_reg(CFG_HOLE_ENTER, CFG_W'(c.hole_enter_um));
        put_reg(CFG_STEP_DANGER, CFG_W'(c.step_danger_um));
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_cfg = c;
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic drain_all();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || sample_if.valid || grade_q.size() != 0);
    endtask

    // flat ground, holes and steps around the baseline, echo loss and full-range raw noise
    task automatic queue_terrain(input hazard_cfg_t c, input int n_items);
        int          added, scene, len, center, unit, thr, depth, jit, lvl, i;
        longint      slant;
        logic [16:0] s;
        s   = (c.slope_q16 > SLOPE_CAP) ? SLOPE_CAP : c.slope_q16;
        thr = int'(c.hole_enter_um);
        if (int'(c.step_enter_um) > thr)
            thr = int'(c.step_enter_um);
        if (int'(c.step_danger_um) > thr)
            thr = int'(c.step_danger_um);
        if (s == 0)
            unit = 50;
        else
        begin
            slant = longint'(thr) * 65536 / longint'(s) / 1000 + 1;
            unit  = (slant > 20000) ? 20000 : int'(slant);
        end
        center = int'(c.baseline_um) / 1000;
        if (center < 1)
            center = 1;
        if (center > 65535)
            center = 65535;
        jit   = unit / 8;
        added = 0;
        while (added < n_items)
        begin
            scene = $urandom_range(9);
            depth = 0;
            case (scene)
                0, 1, 2: len = $urandom_range(10, 2);
                3, 4, 5:
                begin
                    len   = $urandom_range(14, 1);
                    depth = int'($urandom_range(3 * unit, unit / 2));
                end
                6, 7:
                begin
                    len   = $urandom_range(8, 1);
                    depth = -int'($urandom_range(2 * unit, unit / 4));
                end
                default: len = $urandom_range(4, 1);
            endcase
            for (i = 0; i < len; i++)
            begin
                if (scene == 8)
                    lvl = 0;
                else if (scene == 9)
                    lvl = int'($urandom_range(65535));
                else
                begin
                    lvl = center + depth + int'($urandom_range(2 * jit)) - jit;
                    if (lvl < 1)
                        lvl = 1;
                    if (lvl > 65535)
                        lvl = 65535;
                end
                sample_q.push_back(lvl[15:0]);
            end
            added += len;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid    <= 1'b0;
            sample_if.range_mm <= '0;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
            begin
                grade_sample(sample_if.range_mm);
                samples_sent++;
            end
            if (!sample_if.valid || sample_if.ready)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    sample_if.valid    <= 1'b1;
                    sample_if.range_mm <= sample_q.pop_front();
                end
                else
                begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (grade_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer risk=%0d kind=%0d dev=%0d", $time,
                             result_if.risk_level, result_if.hazard_kind,
                             result_if.deviation_um);
                    errors++;
                end
                else
                begin
                    want = grade_q.pop_front();
                    checked++;
                    if (result_if.risk_level !== want.risk
                        || result_if.hazard_kind !== want.kind
                        || result_if.deviation_um !== want.dev)
                    begin
                        $display("%0t: mismatch expected risk=%0d kind=%0d dev=%0d, got %0d %0d %0d",
                                 $time, want.risk, want.kind, want.dev, result_if.risk_level,
                                 result_if.hazard_kind, result_if.deviation_um);
                        errors++;
                    end
                    if (want.risk == LEVEL_CAUTION)
                        hole_cautions++;
                    else if (want.risk == LEVEL_DANGER && want.kind == KIND_HOLE)
                        hole_dangers++;
                    else if (want.risk == LEVEL_DANGER)
                        step_dangers++;
                    else if (want.dev == '0)
                        blanks++;
                end
            end
            result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready)
            || (result_if.valid && result_if.ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        int p;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BASELINE;
        cfg_data           = '0;
        sample_if.valid    = 1'b0;
        sample_if.range_mm = '0;
        result_if.ready    = 1'b0;

        setting[0] = '{26'd300000, 17'd46341, 16'd12000, 20'd6000,
                       20'd42000, 20'd20000, 20'd40000, 20'd40000};
        setting[1] = '{26'h3FFFFFF, 17'h1FFFF, 16'hFFFF, 20'hFFFFF,
                       20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
        setting[2] = '{26'd0, 17'd0, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        setting[3] = '{26'd500000, 17'h18000, 16'd5000, 20'd20000,
                       20'd60000, 20'd15000, 20'd30000, 20'd50000};
        setting[4] = '{26'd150000, 17'd32768, 16'd1000, 20'd0,
                       20'd9000, 20'd5000, 20'd12000, 20'd12000};
        setting[5] = '{26'd1000000, 17'd60000, 16'd30000, 20'd100000,
                       20'd400000, 20'd100000, 20'd200000, 20'd300000};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: no echo, field extremes, median warm-up
        foreach (warmup_mm[i])
            sample_q.push_back(warmup_mm[i][15:0]);
        drain_all();

        // hole to caution and danger, exit grading, step to danger, echo loss
        write_settings(setting[0]);
        foreach (terrain_mm[i])
            sample_q.push_back(terrain_mm[i][15:0]);
        drain_all();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                src_idle_pct = 10;
                snk_idle_pct = 47;
            end
            else if (p < 4)
            begin
                src_idle_pct = 47;
                snk_idle_pct = 10;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_settings(setting[p]);
            queue_terrain(setting[p], phase_items[p]);
            drain_all();
        end

        repeat (12) @(posedge clk);
        $display("%0d samples, %0d grades checked over %0d register settings",
                 samples_sent, checked, NUM_PHASES + 1);
        $display("hole caution %0d, hole danger %0d, step danger %0d, quiet safe %0d",
                 hole_cautions, hole_dangers, step_dangers, blanks);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
